@@ sv/bl3i_pkg.sv @@
// -----------------------------------------------------------------------------
// bl3i_pkg
// Shared types and constants for the 3D line interior voxel walker.
// -----------------------------------------------------------------------------
package bl3i_pkg;

	localparam int COORD_W = 16;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] start_z;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] end_z;
	} bl3i_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic                      last_point;
		logic                      too_long;
	} bl3i_out_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} bl3i_axis_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_STEP,
		ST_LONG
	} bl3i_state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic step;
		logic emit_long;
	} bl3i_cmd_t;

	typedef struct packed {
		logic short_line;
		logic long_line;
		logic last_step;
	} bl3i_sts_t;

endpackage

@@ sv/bl3i_ctrl.sv @@
// -----------------------------------------------------------------------------
// bl3i_ctrl
// Sequencer for the line walker: load, classify, step, and output valid.
// -----------------------------------------------------------------------------
module bl3i_ctrl
	import bl3i_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  bl3i_sts_t sts,
	output bl3i_cmd_t cmd
);

	bl3i_state_t state_q;
	bl3i_state_t state_d;
	logic        out_valid_q;
	logic        out_valid_d;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				if (sts.short_line) begin
					state_d = ST_IDLE;
				end else if (sts.long_line) begin
					state_d = ST_LONG;
				end else begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (slot_free) begin
					cmd.step = 1'b1;
					if (sts.last_step) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_LONG: begin
				if (slot_free) begin
					cmd.emit_long = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (cmd.step || cmd.emit_long) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.emit_long) |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while held");

	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_PREP))
		else $error("accepted item not classified next");

	a_short_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREP && sts.short_line) |=> (state_q == ST_IDLE && !out_valid_q)
		|| (state_q == ST_IDLE && $past(out_valid_q)))
		else $error("short line produced a result");

	a_long_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_long |=> (out_valid && state_q == ST_IDLE))
		else $error("too-long result not presented");
`endif

endmodule

@@ sv/bl3i_dp.sv @@
// -----------------------------------------------------------------------------
// bl3i_dp
// Datapath: axis differences, major axis pick, error terms, voxel stepping
// and the output register.
// -----------------------------------------------------------------------------
module bl3i_dp
	import bl3i_pkg::*;
#(
	parameter int MAX_POINTS = 64
)
(
	input  logic      clk,
	input  bl3i_in_t  in_data,
	input  bl3i_cmd_t cmd,
	output bl3i_sts_t sts,
	output bl3i_out_t out_data
);

	localparam int SW = $clog2(MAX_POINTS + 2);
	localparam int EW = SW + 2;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic [COORD_W-1:0] LONG_LIM = COORD_W'(MAX_POINTS + 1);

	logic signed [COORD_W-1:0] start_v [3];
	logic signed [COORD_W-1:0] end_v   [3];
	logic signed [COORD_W:0]   diff_v  [3];
	logic        [COORD_W-1:0] abs_v   [3];

	logic signed [COORD_W-1:0] pt_q  [3];
	logic        [COORD_W-1:0] dif_q [3];
	logic                      neg_q [3];

	bl3i_axis_t        mj_d;
	bl3i_axis_t        mj_q;
	logic [COORD_W-1:0] span_full;
	logic [COORD_W-1:0] dm1_full;
	logic [COORD_W-1:0] dm2_full;

	logic [SW-1:0]        span_q;
	logic [SW-1:0]        dm1_q;
	logic [SW-1:0]        dm2_q;
	logic signed [EW-1:0] e1_q;
	logic signed [EW-1:0] e2_q;
	logic [CW-1:0]        cnt_q;

	logic signed [EW-1:0] tw_span;
	logic signed [EW-1:0] tw_dm1;
	logic signed [EW-1:0] tw_dm2;
	logic signed [EW-1:0] e1_init;
	logic signed [EW-1:0] e2_init;
	logic signed [EW-1:0] e1_next;
	logic signed [EW-1:0] e2_next;
	logic                 e1_pos;
	logic                 e2_pos;
	logic                 mv [3];
	logic signed [COORD_W-1:0] pt_next [3];

	bl3i_out_t out_q;

	assign start_v[0] = in_data.start_x;
	assign start_v[1] = in_data.start_y;
	assign start_v[2] = in_data.start_z;
	assign end_v[0]   = in_data.end_x;
	assign end_v[1]   = in_data.end_y;
	assign end_v[2]   = in_data.end_z;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			diff_v[a] = {end_v[a][COORD_W-1], end_v[a]} - {start_v[a][COORD_W-1], start_v[a]};
			abs_v[a]  = diff_v[a][COORD_W] ? COORD_W'(-diff_v[a]) : diff_v[a][COORD_W-1:0];
		end
	end

	// pick major axis, ties to x then y
	always_comb begin
		if (dif_q[0] >= dif_q[1] && dif_q[0] >= dif_q[2]) begin
			mj_d     = AXIS_X;
			span_full = dif_q[0];
			dm1_full  = dif_q[1];
			dm2_full  = dif_q[2];
		end else if (dif_q[1] >= dif_q[2]) begin
			mj_d     = AXIS_Y;
			span_full = dif_q[1];
			dm1_full  = dif_q[0];
			dm2_full  = dif_q[2];
		end else begin
			mj_d     = AXIS_Z;
			span_full = dif_q[2];
			dm1_full  = dif_q[0];
			dm2_full  = dif_q[1];
		end
	end

	assign e1_init = $signed({1'b0, dm1_full[SW-1:0], 1'b0}) - $signed({2'b00, span_full[SW-1:0]});
	assign e2_init = $signed({1'b0, dm2_full[SW-1:0], 1'b0}) - $signed({2'b00, span_full[SW-1:0]});

	assign tw_span = $signed({1'b0, span_q, 1'b0});
	assign tw_dm1  = $signed({1'b0, dm1_q, 1'b0});
	assign tw_dm2  = $signed({1'b0, dm2_q, 1'b0});
	assign e1_pos  = (e1_q > 0);
	assign e2_pos  = (e2_q > 0);
	assign e1_next = e1_q - (e1_pos ? tw_span : EW'(0)) + tw_dm1;
	assign e2_next = e2_q - (e2_pos ? tw_span : EW'(0)) + tw_dm2;

	always_comb begin
		case (mj_q)
			AXIS_X: begin
				mv[0] = 1'b1;
				mv[1] = e1_pos;
				mv[2] = e2_pos;
			end
			AXIS_Y: begin
				mv[0] = e1_pos;
				mv[1] = 1'b1;
				mv[2] = e2_pos;
			end
			AXIS_Z: begin
				mv[0] = e1_pos;
				mv[1] = e2_pos;
				mv[2] = 1'b1;
			end
			default: begin
				mv[0] = 1'b0;
				mv[1] = 1'b0;
				mv[2] = 1'b0;
			end
		endcase
		for (int a = 0; a < 3; a++) begin
			if (mv[a]) begin
				pt_next[a] = pt_q[a] + (neg_q[a] ? {COORD_W{1'b1}} : COORD_W'(1));
			end else begin
				pt_next[a] = pt_q[a];
			end
		end
	end

	assign sts.short_line = (span_full[COORD_W-1:1] == '0);
	assign sts.long_line  = (span_full > LONG_LIM);
	assign sts.last_step  = (cnt_q == CW'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int a = 0; a < 3; a++) begin
				pt_q[a]  <= start_v[a];
				dif_q[a] <= abs_v[a];
				neg_q[a] <= diff_v[a][COORD_W];
			end
		end
		if (cmd.prep) begin
			mj_q   <= mj_d;
			span_q <= span_full[SW-1:0];
			dm1_q  <= dm1_full[SW-1:0];
			dm2_q  <= dm2_full[SW-1:0];
			e1_q   <= e1_init;
			e2_q   <= e2_init;
			cnt_q  <= span_full[CW-1:0] - CW'(1);
		end
		if (cmd.step) begin
			for (int a = 0; a < 3; a++) begin
				pt_q[a] <= pt_next[a];
			end
			e1_q  <= e1_next;
			e2_q  <= e2_next;
			cnt_q <= cnt_q - CW'(1);
			out_q.point_x    <= pt_next[0];
			out_q.point_y    <= pt_next[1];
			out_q.point_z    <= pt_next[2];
			out_q.last_point <= sts.last_step;
			out_q.too_long   <= 1'b0;
		end
		if (cmd.emit_long) begin
			out_q.point_x    <= '0;
			out_q.point_y    <= '0;
			out_q.point_z    <= '0;
			out_q.last_point <= 1'b1;
			out_q.too_long   <= 1'b1;
		end
	end

	assign out_data = out_q;

endmodule

@@ sv/bresenham_line_3d_interior_top.sv @@
// -----------------------------------------------------------------------------
// bresenham_line_3d_interior_top
// Emits the voxels strictly between two 3D points along a Bresenham line.
//
//   channel   signals                        payload
//   input     in_valid / in_ready            in_data  (bl3i_in_t)
//   output    out_valid / out_ready          out_data (bl3i_out_t)
//
// Endpoints are captured when idle, then the prep state picks the major
// axis and seeds the error terms; the stepper then emits one voxel per cycle
// while the output register is free. Short lines return from prep to idle with
// no result; a too-long line emits one marker from the long state. A held
// result stalls only the stepper and the marker; the next item waits for idle.
// Reset clears the sequencer and the output valid; no memory to sweep.
// -----------------------------------------------------------------------------
module bresenham_line_3d_interior_top
	import bl3i_pkg::*;
#(
	parameter int MAX_POINTS = 64
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  bl3i_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output bl3i_out_t out_data
);

	bl3i_cmd_t cmd;
	bl3i_sts_t sts;

	bl3i_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bl3i_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk      (clk),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

@@ verif/bresenham_line_3d_interior_top_tb.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// bresenham_line_3d_interior_top_tb
// Self-checking bench for the 3D line interior voxel walker.
//
// A queue of endpoint pairs feeds a valid/ready driver. Every transfer into the
// block is run through a line walker in the bench, which queues the voxels the
// block must return. A monitor compares each output transfer field by field
// with the oldest queued voxel. Stimulus is a directed set of edge cases, then
// random lines, mostly short and well formed, with some full-range noise.
// The run goes through three idle mixes and one long output hold-off.
// -----------------------------------------------------------------------------
module bresenham_line_3d_interior_top_tb;
	import bl3i_pkg::*;

	localparam int MAX_POINTS = 64;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 100;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	bl3i_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	bl3i_out_t out_data;

	bl3i_in_t  line_q[$];
	bl3i_out_t voxel_q[$];

	logic in_taken;
	int   snd_idle_pct;
	int   rcv_idle_pct;
	bit   hold_start;
	bit   hold_used;
	int   hold_left;
	int   stall_cnt;
	int   err_cnt;

	bresenham_line_3d_interior_top #(
		.MAX_POINTS(MAX_POINTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bl3i_in_t make_line(input int sx, input int sy, input int sz,
			input int ex, input int ey, input int ez);
		bl3i_in_t it;
		it.start_x = 16'(sx);
		it.start_y = 16'(sy);
		it.start_z = 16'(sz);
		it.end_x   = 16'(ex);
		it.end_y   = 16'(ey);
		it.end_z   = 16'(ez);
		return it;
	endfunction

	function automatic bl3i_in_t rand_line(input int max_span);
		int org[3];
		int dif[3];
		int mj;
		int span;
		mj = $urandom_range(2);
		span = $urandom_range(max_span);
		for (int a = 0; a < 3; a++) begin
			org[a] = $urandom;
			dif[a] = (a == mj) ? span : $urandom_range(span);
			if ($urandom_range(1))
				dif[a] = -dif[a];
		end
		return make_line(org[0], org[1], org[2],
			org[0] + dif[0], org[1] + dif[1], org[2] + dif[2]);
	endfunction

	// walk the line and queue every interior voxel, or the too-long marker
	task automatic walk_line(input bl3i_in_t it);
		int org[3];
		int dst[3];
		int pos[3];
		int dif[3];
		int dir[3];
		int mj;
		int m1;
		int m2;
		int span;
		int e1;
		int e2;
		int n;
		bl3i_out_t vox;
		org[0] = $signed(it.start_x);
		org[1] = $signed(it.start_y);
		org[2] = $signed(it.start_z);
		dst[0] = $signed(it.end_x);
		dst[1] = $signed(it.end_y);
		dst[2] = $signed(it.end_z);
		for (int a = 0; a < 3; a++) begin
			pos[a] = org[a];
			dir[a] = (dst[a] < org[a]) ? -1 : 1;
			dif[a] = (dst[a] < org[a]) ? org[a] - dst[a] : dst[a] - org[a];
		end
		if (dif[0] >= dif[1] && dif[0] >= dif[2]) begin
			mj = AXIS_X; m1 = AXIS_Y; m2 = AXIS_Z;
		end else if (dif[1] >= dif[2]) begin
			mj = AXIS_Y; m1 = AXIS_X; m2 = AXIS_Z;
		end else begin
			mj = AXIS_Z; m1 = AXIS_X; m2 = AXIS_Y;
		end
		span = dif[mj];
		if (span <= 1)
			return;
		if (span > MAX_POINTS + 1) begin
			vox = '0;
			vox.last_point = 1'b1;
			vox.too_long = 1'b1;
			voxel_q.push_back(vox);
			return;
		end
		n = span - 1;
		e1 = 2 * dif[m1] - span;
		e2 = 2 * dif[m2] - span;
		for (int k = 0; k < n; k++) begin
			if (e1 > 0) begin
				pos[m1] += dir[m1];
				e1 -= 2 * span;
			end
			if (e2 > 0) begin
				pos[m2] += dir[m2];
				e2 -= 2 * span;
			end
			e1 += 2 * dif[m1];
			e2 += 2 * dif[m2];
			pos[mj] += dir[mj];
			vox.point_x = 16'(pos[0]);
			vox.point_y = 16'(pos[1]);
			vox.point_z = 16'(pos[2]);
			vox.last_point = (k == n - 1);
			vox.too_long = 1'b0;
			voxel_q.push_back(vox);
		end
	endtask

	task automatic fill_random(input int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 15)
				line_q.push_back(bl3i_in_t'({$urandom, $urandom, $urandom}));
			else if (r < 30)
				line_q.push_back(rand_line(70));
			else
				line_q.push_back(rand_line(10));
		end
	endtask

	// driver: hold the item until transfer, then offer the next one
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (line_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
					in_data <= line_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_start && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		bl3i_out_t want;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready)
				walk_line(in_data);
			if (out_valid && out_ready) begin
				if (voxel_q.size() == 0) begin
					$error("unexpected result %p", out_data);
					err_cnt++;
				end else begin
					want = voxel_q.pop_front();
					if (out_data.point_x !== want.point_x) begin
						$error("point_x: expected %0d, got %0d", want.point_x, out_data.point_x);
						err_cnt++;
					end
					if (out_data.point_y !== want.point_y) begin
						$error("point_y: expected %0d, got %0d", want.point_y, out_data.point_y);
						err_cnt++;
					end
					if (out_data.point_z !== want.point_z) begin
						$error("point_z: expected %0d, got %0d", want.point_z, out_data.point_z);
						err_cnt++;
					end
					if (out_data.last_point !== want.last_point) begin
						$error("last_point: expected %0b, got %0b",
							want.last_point, out_data.last_point);
						err_cnt++;
					end
					if (out_data.too_long !== want.too_long) begin
						$error("too_long: expected %0b, got %0b", want.too_long, out_data.too_long);
						err_cnt++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		in_taken = 1'b0;
		hold_start = 1'b0;
		hold_used = 1'b0;
		hold_left = 0;
		stall_cnt = 0;
		err_cnt = 0;
		snd_idle_pct = 29;
		rcv_idle_pct = 67;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		line_q.push_back(make_line(0, 0, 0, 0, 0, 0));
		line_q.push_back(make_line(1234, -4321, 7, 1234, -4321, 7));
		line_q.push_back(make_line(0, 0, 0, 1, 0, 0));
		line_q.push_back(make_line(0, 0, 0, 1, 1, 1));
		line_q.push_back(make_line(-32768, 32767, 0, -32767, 32766, 1));
		line_q.push_back(make_line(0, 0, 0, 2, 0, 0));
		line_q.push_back(make_line(32765, 0, 0, 32767, 0, 0));
		line_q.push_back(make_line(0, 0, 0, 4, 2, 1));
		line_q.push_back(make_line(0, 0, 0, 65, 20, -7));
		line_q.push_back(make_line(5, 100, -3, -10, 35, 40));
		line_q.push_back(make_line(32767, -32768, 32767, 32737, -32756, 32702));
		line_q.push_back(make_line(-32768, 0, 0, -32703, -64, 64));
		line_q.push_back(make_line(0, 0, 0, -64, -32, -1));
		line_q.push_back(make_line(0, 0, 0, 66, 0, 0));
		line_q.push_back(make_line(0, 0, 0, 3, 66, -5));
		line_q.push_back(make_line(100, 200, 300, 100, 200, 234));
		line_q.push_back(make_line(-32768, -32768, -32768, 32767, 32767, 32767));
		line_q.push_back(make_line(32767, 32767, 32767, -32768, -32768, -32768));
		line_q.push_back(make_line(32767, 0, 0, -32768, 0, 0));
		line_q.push_back(make_line(0, 0, 0, 10, 10, 10));
		line_q.push_back(make_line(1, 2, 3, -6, -5, 3));
		line_q.push_back(make_line(0, 0, 0, 2, 9, -9));
		line_q.push_back(make_line(0, 0, 0, -9, 3, 9));
		fill_random(65);
		while (line_q.size() != 0)
			@(posedge clk);

		snd_idle_pct = 67;
		rcv_idle_pct = 29;
		fill_random(90);
		while (line_q.size() != 0)
			@(posedge clk);

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		fill_random(90);
		hold_start = 1'b1;
		while (line_q.size() != 0 || in_valid || voxel_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (err_cnt == 0 && voxel_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			if (voxel_q.size() != 0)
				$error("%0d expected results never arrived", voxel_q.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ bresenham_line_3d_interior_top.f @@
sv/bl3i_pkg.sv
sv/bl3i_ctrl.sv
sv/bl3i_dp.sv
sv/bresenham_line_3d_interior_top.sv
verif/bresenham_line_3d_interior_top_tb.sv
